// File: design/lci_pkg.sv
// Shared types, constants and rounding and saturation helpers for the line/circle intersection block.
package lci_pkg;

    // Fraction bits of the direction vector (Q2.14).
    localparam int DIR_FRAC_BITS = 14;

    // Steps of the digit-by-digit square root over a 64-bit radicand.
    localparam int SQRT_STEPS = 32;
    localparam int SQ_W = 64;

    // Widths of the input and result streams, padded to whole bytes.
    localparam int IN_DATA_W = 192;
    localparam int OUT_DATA_W = 136;

    // Result classes carried in hit_count.
    localparam logic [1:0] HITS_NONE = 2'd0;
    localparam logic [1:0] HITS_TANGENT = 2'd1;
    localparam logic [1:0] HITS_TWO = 2'd2;

    // Values that ride along with the square root.
    typedef struct packed {
        logic [1:0] hits;
        logic signed [32:0] d;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } side_t;

    // Data handed from one square-root cell to the next.
    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] res;
        side_t side;
    } sq_t;

    // One result item; hit_count sits in the lowest bits.
    typedef struct packed {
        logic signed [31:0] second_y;
        logic signed [31:0] second_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_x;
        logic [1:0] hit_count;
    } res_t;

    // Divide by 2^DIR_FRAC_BITS, rounding to nearest with ties away from zero.
    function automatic logic signed [36:0] round_shift(input logic signed [49:0] v);
        logic signed [50:0] t;
        logic signed [50:0] sh;
        t = 51'(v) + (51'sd1 <<< (DIR_FRAC_BITS - 1)) - 51'(v[49] ? 2'sd1 : 2'sd0);
        sh = t >>> DIR_FRAC_BITS;
        return sh[36:0];
    endfunction

    // Saturate to a signed 32-bit coordinate.
    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > 38'sh007FFFFFFF)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -38'sh0080000000)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: design/line_circle_intersection_top.sv
// Top level of the 2D line/circle intersection pipeline with its stream and register ports.
//
// Each transfer on the s_ side carries one query: a line given by an origin and a
// unit direction (Q2.14) and a circle given by center and radius (Q16.16). Each query
// yields exactly one transfer on the m_ side with hit_count 0, 1 or 2 and the points.
// Two points are reported when the line crosses the circle, one tangent point when it
// misses by no more than the tangent tolerance, and none otherwise; unused coordinate
// fields are zero and every coordinate saturates to signed 32 bits.
// The tolerance register is written through cfg_valid/cfg_data, always ready, and
// is meant to be changed only while no query is in flight. Reset sets it to 1.
// A query passes through seven front-end stages, a chain of 32 square-root cells
// (one root bit per cell), five point stages and the output register before m_tvalid.
// One query is accepted per cycle while s_tready is high; the root chain is fully
// pipelined, so nothing iterates in place.
// When the receiver stalls, the output register holds its result and one further
// result lands in a skid entry; only then does s_tready drop and the whole pipeline
// freeze. Reset empties the pipeline and the output; no result is lost or repeated.
module line_circle_intersection_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // origin_x[31:0], origin_y[63:32], dir_x[79:64], dir_y[95:80],
    // center_x[127:96], center_y[159:128], radius[190:160], zero pad[191]
    input  logic [lci_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // hit_count[1:0], first_x[33:2], first_y[65:34], second_x[97:66],
    // second_y[129:98], zero pad[135:130]
    output logic [lci_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [30:0]                       cfg_data
);

    logic [30:0]   tol_reg;
    logic          en;
    logic          skid_full;

    logic          front_valid;
    lci_pkg::sq_t  front_data;

    logic          chain_valid [0:lci_pkg::SQRT_STEPS];
    lci_pkg::sq_t  chain_data  [0:lci_pkg::SQRT_STEPS];

    logic          pts_valid;
    lci_pkg::res_t pts_data;
    lci_pkg::res_t out_data;

    // Tangent tolerance register; writes are always accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= 31'd1;
        end
        else if (cfg_valid)
        begin
            tol_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // The pipeline advances in every cycle unless the skid entry is occupied.
    assign en       = !skid_full;
    assign s_tready = en;

    lci_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .origin_x  (s_tdata[31:0]),
        .origin_y  (s_tdata[63:32]),
        .dir_x     (s_tdata[79:64]),
        .dir_y     (s_tdata[95:80]),
        .center_x  (s_tdata[127:96]),
        .center_y  (s_tdata[159:128]),
        .radius    (s_tdata[190:160]),
        .tolerance (tol_reg),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    assign chain_valid[0] = front_valid;
    assign chain_data[0]  = front_data;

    // Each cell settles one bit of the root, starting from the top bit pair.
    for (genvar k = 0; k < lci_pkg::SQRT_STEPS; k++)
    begin : g_cell
        lci_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step_bit  (64'd1 << (2 * (lci_pkg::SQRT_STEPS - 1 - k))),
            .in_valid  (chain_valid[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    lci_points u_points (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (chain_valid[lci_pkg::SQRT_STEPS]),
        .in_data   (chain_data[lci_pkg::SQRT_STEPS]),
        .out_valid (pts_valid),
        .out_data  (pts_data)
    );

    lci_out_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pts_valid && en),
        .push_data (pts_data),
        .full      (skid_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {6'd0, out_data};

endmodule

// File: design/lci_dist.sv
// Front end: signed distance of the line from the center, classification and radicand.
module lci_dist (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [31:0]  origin_x,
    input  logic signed [31:0]  origin_y,
    input  logic signed [15:0]  dir_x,
    input  logic signed [15:0]  dir_y,
    input  logic signed [31:0]  center_x,
    input  logic signed [31:0]  center_y,
    input  logic [30:0]         radius,
    input  logic [30:0]         tolerance,
    output logic                out_valid,
    output lci_pkg::sq_t        out_data
);

    logic [6:0] valid_reg;

    // Stage 0: offset of the origin from the center.
    logic signed [32:0] f0_ex_reg, f0_ey_reg;
    logic signed [15:0] f0_dx_reg, f0_dy_reg;
    logic signed [31:0] f0_cx_reg, f0_cy_reg;
    logic [30:0]        f0_r_reg;
    // Stage 1: the two cross-product terms.
    logic signed [48:0] f1_p1_reg, f1_p2_reg;
    logic signed [15:0] f1_dx_reg, f1_dy_reg;
    logic signed [31:0] f1_cx_reg, f1_cy_reg;
    logic [30:0]        f1_r_reg;
    // Stage 2: exact cross product.
    logic signed [49:0] f2_s_reg;
    logic signed [15:0] f2_dx_reg, f2_dy_reg;
    logic signed [31:0] f2_cx_reg, f2_cy_reg;
    logic [30:0]        f2_r_reg;
    // Stage 3: rounded distance.
    logic signed [36:0] f3_d_reg;
    logic signed [15:0] f3_dx_reg, f3_dy_reg;
    logic signed [31:0] f3_cx_reg, f3_cy_reg;
    logic [30:0]        f3_r_reg;
    // Stage 4: magnitude of the distance.
    logic [35:0]        f4_c_reg;
    logic signed [32:0] f4_d_reg;
    logic signed [15:0] f4_dx_reg, f4_dy_reg;
    logic signed [31:0] f4_cx_reg, f4_cy_reg;
    logic [30:0]        f4_r_reg;
    // Stage 5: class and squares.
    logic [61:0]        f5_rr_reg, f5_cc_reg;
    lci_pkg::side_t     f5_side_reg;
    // Stage 6: radicand.
    logic [61:0]        f6_n_reg;
    lci_pkg::side_t     f6_side_reg;

    logic [1:0]  hits_next;
    logic [31:0] reach_next;

    always_comb
    begin
        reach_next = {1'b0, f4_r_reg} + {1'b0, tolerance};
        if (f4_c_reg < {5'd0, f4_r_reg})
        begin
            hits_next = lci_pkg::HITS_TWO;
        end
        else if (f4_c_reg <= {4'd0, reach_next})
        begin
            hits_next = lci_pkg::HITS_TANGENT;
        end
        else
        begin
            hits_next = lci_pkg::HITS_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f0_ex_reg <= 33'(origin_x) - 33'(center_x);
            f0_ey_reg <= 33'(origin_y) - 33'(center_y);
            f0_dx_reg <= dir_x;
            f0_dy_reg <= dir_y;
            f0_cx_reg <= center_x;
            f0_cy_reg <= center_y;
            f0_r_reg  <= radius;

            f1_p1_reg <= f0_ex_reg * 49'(f0_dy_reg);
            f1_p2_reg <= f0_ey_reg * 49'(f0_dx_reg);
            f1_dx_reg <= f0_dx_reg;
            f1_dy_reg <= f0_dy_reg;
            f1_cx_reg <= f0_cx_reg;
            f1_cy_reg <= f0_cy_reg;
            f1_r_reg  <= f0_r_reg;

            f2_s_reg  <= 50'(f1_p1_reg) - 50'(f1_p2_reg);
            f2_dx_reg <= f1_dx_reg;
            f2_dy_reg <= f1_dy_reg;
            f2_cx_reg <= f1_cx_reg;
            f2_cy_reg <= f1_cy_reg;
            f2_r_reg  <= f1_r_reg;

            f3_d_reg  <= lci_pkg::round_shift(f2_s_reg);
            f3_dx_reg <= f2_dx_reg;
            f3_dy_reg <= f2_dy_reg;
            f3_cx_reg <= f2_cx_reg;
            f3_cy_reg <= f2_cy_reg;
            f3_r_reg  <= f2_r_reg;

            f4_c_reg  <= f3_d_reg[36] ? 36'(-f3_d_reg) : 36'(f3_d_reg);
            f4_d_reg  <= f3_d_reg[32:0];
            f4_dx_reg <= f3_dx_reg;
            f4_dy_reg <= f3_dy_reg;
            f4_cx_reg <= f3_cx_reg;
            f4_cy_reg <= f3_cy_reg;
            f4_r_reg  <= f3_r_reg;

            // The squares only matter when the line crosses, where c fits in 31 bits.
            f5_rr_reg        <= 62'(f4_r_reg) * 62'(f4_r_reg);
            f5_cc_reg        <= 62'(f4_c_reg[30:0]) * 62'(f4_c_reg[30:0]);
            f5_side_reg.hits <= hits_next;
            f5_side_reg.d    <= f4_d_reg;
            f5_side_reg.dx   <= f4_dx_reg;
            f5_side_reg.dy   <= f4_dy_reg;
            f5_side_reg.cx   <= f4_cx_reg;
            f5_side_reg.cy   <= f4_cy_reg;

            f6_n_reg    <= f5_rr_reg - f5_cc_reg;
            f6_side_reg <= f5_side_reg;
        end
    end

    assign out_valid     = valid_reg[6];
    assign out_data.rem  = {2'b00, f6_n_reg};
    assign out_data.res  = '0;
    assign out_data.side = f6_side_reg;

endmodule

// File: design/lci_sqrt_cell.sv
// One step of the digit-by-digit square root, registered, with its side data.
module lci_sqrt_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [lci_pkg::SQ_W-1:0]   step_bit,
    input  logic                       in_valid,
    input  lci_pkg::sq_t               in_data,
    output logic                       out_valid,
    output lci_pkg::sq_t               out_data
);

    logic                      valid_reg;
    lci_pkg::sq_t              data_reg;
    lci_pkg::sq_t              data_next;
    logic [lci_pkg::SQ_W-1:0]  trial;

    always_comb
    begin
        trial = in_data.res + step_bit;
        data_next = in_data;
        if (in_data.rem >= trial)
        begin
            data_next.rem = in_data.rem - trial;
            data_next.res = (in_data.res >> 1) + step_bit;
        end
        else
        begin
            data_next.res = in_data.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: design/lci_points.sv
// Back end: rounds the root and forms the saturated intersection or tangent points.
module lci_points (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  lci_pkg::sq_t   in_data,
    output logic           out_valid,
    output lci_pkg::res_t  out_data
);

    logic [4:0] valid_reg;

    logic [31:0]        p0_a_reg;
    lci_pkg::side_t     p0_side_reg;
    logic signed [48:0] p1_m1_reg, p1_m2_reg, p1_m3_reg, p1_m4_reg;
    logic signed [31:0] p1_cx_reg, p1_cy_reg;
    logic [1:0]         p1_hits_reg;
    logic signed [49:0] p2_fx_reg, p2_fy_reg, p2_sx_reg, p2_sy_reg;
    logic signed [31:0] p2_cx_reg, p2_cy_reg;
    logic [1:0]         p2_hits_reg;
    logic signed [36:0] p3_fx_reg, p3_fy_reg, p3_sx_reg, p3_sy_reg;
    logic signed [31:0] p3_cx_reg, p3_cy_reg;
    logic [1:0]         p3_hits_reg;
    lci_pkg::res_t      p4_res_reg;

    logic [31:0]        a_next;
    logic signed [32:0] a_s;
    lci_pkg::res_t      res_next;

    always_comb
    begin
        // Round the root to nearest; the offset is zero unless the line crosses.
        if (in_data.side.hits == lci_pkg::HITS_TWO)
        begin
            a_next = in_data.res[31:0] + {31'd0, in_data.rem > in_data.res};
        end
        else
        begin
            a_next = '0;
        end
        a_s = signed'({1'b0, p0_a_reg});
    end

    always_comb
    begin
        res_next = '0;
        res_next.hit_count = p3_hits_reg;
        if (p3_hits_reg != lci_pkg::HITS_NONE)
        begin
            res_next.first_x = lci_pkg::sat32(38'(p3_cx_reg) + 38'(p3_fx_reg));
            res_next.first_y = lci_pkg::sat32(38'(p3_cy_reg) + 38'(p3_fy_reg));
        end
        if (p3_hits_reg == lci_pkg::HITS_TWO)
        begin
            res_next.second_x = lci_pkg::sat32(38'(p3_cx_reg) + 38'(p3_sx_reg));
            res_next.second_y = lci_pkg::sat32(38'(p3_cy_reg) + 38'(p3_sy_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_a_reg    <= a_next;
            p0_side_reg <= in_data.side;

            p1_m1_reg   <= 49'(p0_side_reg.dy) * 49'(p0_side_reg.d);
            p1_m2_reg   <= 49'(p0_side_reg.dx) * 49'(a_s);
            p1_m3_reg   <= 49'(p0_side_reg.dx) * 49'(p0_side_reg.d);
            p1_m4_reg   <= 49'(p0_side_reg.dy) * 49'(a_s);
            p1_cx_reg   <= p0_side_reg.cx;
            p1_cy_reg   <= p0_side_reg.cy;
            p1_hits_reg <= p0_side_reg.hits;

            p2_fx_reg   <= 50'(p1_m1_reg) - 50'(p1_m2_reg);
            p2_fy_reg   <= -50'(p1_m3_reg) - 50'(p1_m4_reg);
            p2_sx_reg   <= 50'(p1_m1_reg) + 50'(p1_m2_reg);
            p2_sy_reg   <= 50'(p1_m4_reg) - 50'(p1_m3_reg);
            p2_cx_reg   <= p1_cx_reg;
            p2_cy_reg   <= p1_cy_reg;
            p2_hits_reg <= p1_hits_reg;

            p3_fx_reg   <= lci_pkg::round_shift(p2_fx_reg);
            p3_fy_reg   <= lci_pkg::round_shift(p2_fy_reg);
            p3_sx_reg   <= lci_pkg::round_shift(p2_sx_reg);
            p3_sy_reg   <= lci_pkg::round_shift(p2_sy_reg);
            p3_cx_reg   <= p2_cx_reg;
            p3_cy_reg   <= p2_cy_reg;
            p3_hits_reg <= p2_hits_reg;

            p4_res_reg  <= res_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_data  = p4_res_reg;

endmodule

// File: design/lci_out_skid.sv
// Output register with one skid entry that decouples the result stream from the pipeline.
module lci_out_skid (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lci_pkg::res_t  push_data,
    output logic           full,
    output logic           out_valid,
    input  logic           out_ready,
    output lci_pkg::res_t  out_data
);

    logic           out_valid_reg;
    logic           skid_valid_reg;
    lci_pkg::res_t  out_data_reg;
    lci_pkg::res_t  skid_data_reg;
    logic           take;

    assign take = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (push && (take || !out_valid_reg))
        begin
            out_data_reg <= push_data;
        end
        if (push && !take && out_valid_reg)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
